[rtl/drup_pkg.sv]
`default_nettype none

package drup_pkg;

    // Default coordinate width of every rectangle edge
    localparam int COORD_BITS_DEF = 10;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Kinds of area a word can produce, in output order
    localparam int NUM_KINDS   = 6;
    localparam int KIND_NEW    = 0;
    localparam int KIND_OLD    = 1;
    localparam int KIND_TOP    = 2;
    localparam int KIND_LEFT   = 3;
    localparam int KIND_RIGHT  = 4;
    localparam int KIND_BOTTOM = 5;

    // Coordinates carried per job: new rect, old rect, overlap rect
    localparam int JOB_COORDS = 12;

endpackage

`default_nettype wire

[rtl/drup_ifs.sv]
`default_nettype none

// Tile word: new and previous state of one tile
interface drup_item_if
    import drup_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  new_visible;
    logic                  old_visible;
    logic                  force_full;
    logic                  appearance_changed;
    logic [COORD_BITS-1:0] new_left;
    logic [COORD_BITS-1:0] new_right;
    logic [COORD_BITS-1:0] new_top;
    logic [COORD_BITS-1:0] new_bottom;
    logic [COORD_BITS-1:0] old_left;
    logic [COORD_BITS-1:0] old_right;
    logic [COORD_BITS-1:0] old_top;
    logic [COORD_BITS-1:0] old_bottom;

    modport source (
        output valid, new_visible, old_visible, force_full, appearance_changed,
        output new_left, new_right, new_top, new_bottom,
        output old_left, old_right, old_top, old_bottom,
        input  ready
    );
    modport sink (
        input  valid, new_visible, old_visible, force_full, appearance_changed,
        input  new_left, new_right, new_top, new_bottom,
        input  old_left, old_right, old_top, old_bottom,
        output ready
    );
endinterface

// Area word: one rectangle to redraw
interface drup_area_if
    import drup_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] area_left;
    logic [COORD_BITS-1:0] area_right;
    logic [COORD_BITS-1:0] area_top;
    logic [COORD_BITS-1:0] area_bottom;
    logic                  is_empty;
    logic                  is_last;

    modport source (
        output valid, area_left, area_right, area_top, area_bottom,
        output is_empty, is_last,
        input  ready
    );
    modport sink (
        input  valid, area_left, area_right, area_top, area_bottom,
        input  is_empty, is_last,
        output ready
    );
endinterface

// Internal job word between front, queue and back
interface drup_job_if
    import drup_pkg::*;
#(
    parameter int WIDTH = NUM_KINDS + JOB_COORDS * COORD_BITS_DEF
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/drup_front.sv]
`default_nettype none

// Classifies a tile word and builds a job: which areas to emit plus the
// rectangles they are cut from.
module drup_front
    import drup_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    drup_item_if.sink  tile,
    drup_job_if.source job
);

    logic [COORD_BITS-1:0] nl, nr, nt, nb;
    logic [COORD_BITS-1:0] ol, orr, ot, ob;
    logic [COORD_BITS-1:0] x1, x2, y1, y2;
    logic                  moved;
    logic                  disjoint;
    logic [NUM_KINDS-1:0]  mask;

    assign nl  = tile.new_left;
    assign nr  = tile.new_right;
    assign nt  = tile.new_top;
    assign nb  = tile.new_bottom;
    assign ol  = tile.old_left;
    assign orr = tile.old_right;
    assign ot  = tile.old_top;
    assign ob  = tile.old_bottom;

    // Overlap of new and old
    assign x1 = (nl > ol)  ? nl : ol;
    assign x2 = (nr < orr) ? nr : orr;
    assign y1 = (nt > ot)  ? nt : ot;
    assign y2 = (nb < ob)  ? nb : ob;

    assign moved    = (nl != ol) || (nr != orr) || (nt != ot) || (nb != ob);
    assign disjoint = (nl > orr) || (nr < ol) || (nt > ob) || (nb < ot);

    // Area selection, highest priority first
    always_comb
    begin
        mask = '0;
        if (!tile.new_visible && !tile.old_visible && !tile.force_full)
        begin
            mask = '0;
        end
        else if ((tile.new_visible && !tile.old_visible) || tile.force_full)
        begin
            mask[KIND_NEW] = 1'b1;
        end
        else if (!tile.new_visible && tile.old_visible)
        begin
            mask[KIND_OLD] = 1'b1;
        end
        else if (moved)
        begin
            mask[KIND_NEW] = 1'b1;
            if (disjoint)
            begin
                mask[KIND_OLD] = 1'b1;
            end
            else
            begin
                mask[KIND_TOP]    = ot < y1;
                mask[KIND_LEFT]   = ol < x1;
                mask[KIND_RIGHT]  = orr > x2;
                mask[KIND_BOTTOM] = ob > y2;
            end
        end
        else if (tile.appearance_changed)
        begin
            mask[KIND_NEW] = 1'b1;
        end
    end

    assign job.valid  = tile.valid;
    assign tile.ready = job.ready;
    assign job.data   = {mask, nl, nr, nt, nb, ol, orr, ot, ob, x1, x2, y1, y2};

endmodule

`default_nettype wire

[rtl/drup_queue.sv]
`default_nettype none

// Short queue of jobs between front and back
module drup_queue
    import drup_pkg::*;
#(
    parameter int WIDTH = NUM_KINDS + JOB_COORDS * COORD_BITS_DEF,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire       clk,
    input  wire       rst_n,
    drup_job_if.sink   push,
    drup_job_if.source pop
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign push.ready = count_reg != (PW+1)'(DEPTH);
    assign pop.valid  = count_reg != '0;
    assign pop.data   = slot_reg[rd_ptr_reg];

    assign do_push = push.valid && push.ready;
    assign do_pop  = pop.valid && pop.ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

`default_nettype wire

[rtl/drup_back.sv]
`default_nettype none

// Walks the area mask of the head job, one area word per cycle while area is
// ready, into an output register.
module drup_back
    import drup_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    drup_job_if.sink    job,
    drup_area_if.source area
);

    localparam int CB = COORD_BITS;
    localparam logic [CB-1:0] ONE = CB'(1);

    logic [NUM_KINDS-1:0] mask;
    logic [CB-1:0]        nl, nr, nt, nb, ol, orr, ot, ob, x1, x2, y1, y2;
    logic [NUM_KINDS-1:0] sent_reg, sent_next;
    logic [NUM_KINDS-1:0] rem, pick, rem_after;
    logic                 fire, last;

    logic                 valid_reg, valid_next;
    logic [CB-1:0]        left_reg, right_reg, top_reg, bottom_reg;
    logic [CB-1:0]        left_next, right_next, top_next, bottom_next;
    logic                 empty_reg, last_reg;

    assign {mask, nl, nr, nt, nb, ol, orr, ot, ob, x1, x2, y1, y2} = job.data;

    // Next area of the head job: lowest pending kind
    assign rem       = mask & ~sent_reg;
    assign pick      = rem & (~rem + 1'b1);
    assign rem_after = rem & ~pick;
    assign last      = rem_after == '0;
    assign fire      = job.valid && (!valid_reg || area.ready);
    assign job.ready = fire && last;

    always_comb
    begin
        left_next   = '0;
        right_next  = '0;
        top_next    = '0;
        bottom_next = '0;
        if (pick[KIND_NEW])
        begin
            {left_next, right_next, top_next, bottom_next} = {nl, nr, nt, nb};
        end
        else if (pick[KIND_OLD])
        begin
            {left_next, right_next, top_next, bottom_next} = {ol, orr, ot, ob};
        end
        else if (pick[KIND_TOP])
        begin
            {left_next, right_next, top_next, bottom_next} = {ol, orr, ot, y1 - ONE};
        end
        else if (pick[KIND_LEFT])
        begin
            {left_next, right_next, top_next, bottom_next} = {ol, x1 - ONE, y1, y2};
        end
        else if (pick[KIND_RIGHT])
        begin
            {left_next, right_next, top_next, bottom_next} = {x2 + ONE, orr, y1, y2};
        end
        else if (pick[KIND_BOTTOM])
        begin
            {left_next, right_next, top_next, bottom_next} = {ol, orr, y2 + ONE, ob};
        end
    end

    // Progress through the head job and output valid
    always_comb
    begin
        sent_next  = sent_reg;
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
            sent_next  = last ? '0 : (sent_reg | pick);
        end
        else if (area.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg  <= sent_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
            empty_reg  <= mask == '0;
            last_reg   <= last;
        end
    end

    assign area.valid       = valid_reg;
    assign area.area_left   = left_reg;
    assign area.area_right  = right_reg;
    assign area.area_top    = top_reg;
    assign area.area_bottom = bottom_reg;
    assign area.is_empty    = empty_reg;
    assign area.is_last     = last_reg;

endmodule

`default_nettype wire

[rtl/dirty_rectangle_difference_unit.sv]
// Dirty-rectangle difference unit.
//
// Channel tile takes one word per tile: visibility now and before, a forced
// redraw flag, an appearance flag, and the new and old inclusive rectangles.
// Channel area returns the rectangles to redraw for that tile, in order
// new, old, then strips top, left, right, bottom; is_last marks the final
// word of the tile. A tile with nothing to redraw yields one word with
// is_empty and is_last set and all edges zero.
//
// A tile accepted into the job queue moves on into the output register
// before its first area word shows. Throughput: while area is ready, the
// back end emits one area word per cycle, and a tile with 1 to 5 areas
// holds it until all are sent; one-area tiles stream at one per cycle. The
// classifier feeds a two-entry job queue, so tile keeps accepting while the
// back end works on earlier tiles. When area stalls, the output register
// holds its word, the queue fills, and tile.ready drops once it is full.
// Reset clears the queue and the output register; no word is pending after.

`default_nettype none

module dirty_rectangle_difference_unit
    import drup_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    drup_item_if.sink   tile,
    drup_area_if.source area
);

    localparam int JOB_W = NUM_KINDS + JOB_COORDS * COORD_BITS;

    drup_job_if #(.WIDTH(JOB_W)) front_job ();
    drup_job_if #(.WIDTH(JOB_W)) back_job ();

    drup_front #(.COORD_BITS(COORD_BITS)) u_front (
        .tile (tile),
        .job  (front_job)
    );

    drup_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_job),
        .pop   (back_job)
    );

    drup_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .job   (back_job),
        .area  (area)
    );

endmodule

`default_nettype wire

[rtl/drup_checker.sv]
`default_nettype none

// Port-level checks for the dirty-rectangle difference unit
module drup_checker
    import drup_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  tile_valid,
    input wire                  tile_ready,
    input wire                  area_valid,
    input wire                  area_ready,
    input wire [COORD_BITS-1:0] area_left,
    input wire [COORD_BITS-1:0] area_right,
    input wire [COORD_BITS-1:0] area_top,
    input wire [COORD_BITS-1:0] area_bottom,
    input wire                  is_empty,
    input wire                  is_last
);

    logic       tile_take, area_done;
    logic [3:0] open_reg, open_next;

    assign tile_take = tile_valid && tile_ready;
    assign area_done = area_valid && area_ready && is_last;

    // Tiles accepted but not fully answered
    always_comb
    begin
        open_next = open_reg;
        if (tile_take && !area_done)
        begin
            open_next = open_reg + 1'b1;
        end
        else if (!tile_take && area_done)
        begin
            open_next = open_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    // A stalled word stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        area_valid && !area_ready |=> area_valid)
        else $error("area word dropped while stalled");

    // A stalled word keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        area_valid && !area_ready |=>
            $stable(area_left) && $stable(area_right) && $stable(area_top)
            && $stable(area_bottom) && $stable(is_empty) && $stable(is_last))
        else $error("area payload changed while stalled");

    // Empty answer is a single zeroed word
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        area_valid && is_empty |->
            is_last && area_left == '0 && area_right == '0
            && area_top == '0 && area_bottom == '0)
        else $error("empty area word malformed");

    // Every area word belongs to an accepted tile
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        area_valid |-> open_reg != '0)
        else $error("area word without an open tile");

endmodule

bind dirty_rectangle_difference_unit drup_checker #(.COORD_BITS(COORD_BITS)) u_drup_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tile_valid  (tile.valid),
    .tile_ready  (tile.ready),
    .area_valid  (area.valid),
    .area_ready  (area.ready),
    .area_left   (area.area_left),
    .area_right  (area.area_right),
    .area_top    (area.area_top),
    .area_bottom (area.area_bottom),
    .is_empty    (area.is_empty),
    .is_last     (area.is_last)
);

`default_nettype wire
